// ===== hdl/ffbp_pkg.sv =====
// Shared types and constants for the first-fit bin packer.
// No dependencies; the top level, the checker and the testbench import this package.
package ffbp_pkg;

  localparam int unsigned MAX_BINS_DEF = 16;
  localparam logic [15:0] CAP_RESET    = 16'hFFFF;
  localparam int unsigned ROOM_W       = 16;

  typedef struct packed {
    logic [15:0] item_size;
    logic        start_new_set;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] bin_number;
    logic       opened_new_bin;
    logic       rejected;
    logic [4:0] bins_in_use;
  } out_beat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } ffbp_state_t;

endpackage

// ===== hdl/first_fit_bin_packer_top.sv =====
// First-fit bin packer: control FSM plus room memory.
// Depends on ffbp_pkg and ffbp_ram.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one item per beat: its size
//   and a flag that empties all bins before the item is placed. Output channel
//   (out_valid/out_ready/out_data) returns one result beat per item: bin index,
//   new-bin flag, reject flag and the number of open bins after the item.
//   cfg_we/cfg_wdata write the capacity given to bins opened afterward; write
//   it only while no item is in flight.
// Timing:
//   One item at a time. The room of each open bin sits in a RAM with registered
//   read data; the scan reads one bin per cycle, overlapping the read of the
//   next bin with the compare of the current one. An item is accepted in S_IDLE,
//   visits at most MAX_BINS bins in S_SCAN and is loaded into the output register
//   from S_EMIT; an oversized item or an empty set skips S_SCAN. The chosen bin is
//   updated by a write in the cycle the scan ends.
// Reset: all bins closed, capacity 65535, output empty. No clearing pass.
// Stall: a result waits in the output register until taken; a finished scan
//   holds in its last state until the output register is free.
module first_fit_bin_packer_top
  import ffbp_pkg::*;
#(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_beat_t  out_data,
  input  logic       cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned CW = $clog2(MAX_BINS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BINS);

  ffbp_state_t state_r, state_nxt;
  logic [15:0]   cap_r;
  logic [15:0]   size_r, size_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] chk_r, chk_nxt;
  logic [IW-1:0] chosen_r, chosen_nxt;
  logic          opened_r, opened_nxt;
  logic          reject_r, reject_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_data_r, out_data_nxt;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [ROOM_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0] count_base;
  logic [CW-1:0] chk_next_cnt;
  logic          fits, last_bin;
  logic [IW+3:0] chosen_ext;
  logic [CW+4:0] count_ext;

  assign chosen_ext   = {4'b0, chosen_r};
  assign count_ext    = {5'b0, count_r};
  assign count_base   = in_data.start_new_set ? '0 : count_r;
  assign chk_next_cnt = CW'(chk_r) + CW'(1);
  assign fits         = (ram_rdata >= size_r);
  assign last_bin     = (chk_next_cnt == count_r);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ffbp_ram #(
    .WIDTH (ROOM_W),
    .DEPTH (MAX_BINS)
  ) u_room_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    chk_r      <= chk_nxt;
    chosen_r   <= chosen_nxt;
    opened_r   <= opened_nxt;
    reject_r   <= reject_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    count_nxt     = count_r;
    chk_nxt       = chk_r;
    chosen_nxt    = chosen_r;
    opened_nxt    = opened_r;
    reject_nxt    = reject_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = chk_r;
    ram_wdata     = ram_rdata - size_r;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          size_nxt   = in_data.item_size;
          count_nxt  = count_base;
          chk_nxt    = '0;
          chosen_nxt = '0;
          opened_nxt = 1'b0;
          reject_nxt = 1'b0;
          state_nxt  = S_EMIT;
          if (in_data.item_size > cap_r) begin
            reject_nxt = 1'b1;
          end else if (count_base == '0) begin
            // Empty set: open bin 0 straight away
            ram_we     = 1'b1;
            ram_waddr  = '0;
            ram_wdata  = cap_r - in_data.item_size;
            count_nxt  = CW'(1);
            opened_nxt = 1'b1;
          end else begin
            ram_re    = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // rdata holds the room of bin chk_r
        if (fits) begin
          ram_we     = 1'b1;
          chosen_nxt = chk_r;
          state_nxt  = S_EMIT;
        end else if (last_bin) begin
          state_nxt = S_EMIT;
          if (count_r < MAX_CNT) begin
            ram_we     = 1'b1;
            ram_waddr  = count_r[IW-1:0];
            ram_wdata  = cap_r - size_r;
            chosen_nxt = count_r[IW-1:0];
            count_nxt  = count_r + CW'(1);
            opened_nxt = 1'b1;
          end else begin
            reject_nxt = 1'b1;
          end
        end else begin
          // Advance: fetch the next bin while this one is dropped
          ram_re    = 1'b1;
          ram_raddr = chk_r + IW'(1);
          chk_nxt   = chk_r + IW'(1);
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.bin_number     = reject_r ? 4'd0 : chosen_ext[3:0];
          out_data_nxt.opened_new_bin = opened_r;
          out_data_nxt.rejected       = reject_r;
          out_data_nxt.bins_in_use    = count_ext[4:0];
          state_nxt                   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/ffbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ffbp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ffbp_checker.sv =====
// Port-level assertions for the first-fit bin packer, bound to the top level.
// Depends on ffbp_pkg and first_fit_bin_packer_top.
module ffbp_checker
  import ffbp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rejected |->
      out_data.bin_number == 4'd0 && !out_data.opened_new_bin)
    else $error("rejected beat carries placement");

  a_open_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.opened_new_bin |->
      out_data.bins_in_use != 5'd0 && !out_data.rejected)
    else $error("new bin reported with no bins in use");

  // One item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_empty_set_opens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.rejected && out_data.bins_in_use == 5'd1 |->
      out_data.bin_number == 4'd0)
    else $error("placement beyond the only open bin");

endmodule

bind first_fit_bin_packer_top ffbp_checker u_ffbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/tb_first_fit_bin_packer_top.sv =====
// Self-checking testbench for first_fit_bin_packer_top: directed corner cases,
// then random item sets under three sender/receiver idling mixes.
// Depends on ffbp_pkg and the packer RTL.
module tb_first_fit_bin_packer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ffbp_pkg::*;

  localparam int NUM_BINS    = MAX_BINS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_PRINTS  = 50;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Packer state as the block should hold it
  logic [15:0] bin_cap = CAP_RESET;
  logic [15:0] bin_room [NUM_BINS];
  int unsigned bins_open = 0;

  out_beat_t   expected_placements [$];
  int          error_count        = 0;
  int          sender_idle_pct    = 0;
  int          receiver_idle_pct  = 0;
  int          quiet_cycles       = 0;

  first_fit_bin_packer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // First-fit placement of one item; updates the bin state
  function automatic out_beat_t place_item(in_beat_t b);
    out_beat_t r;
    logic      found;
    r = '0;
    r.rejected = 1'b1;
    found = 1'b0;
    if (b.start_new_set) begin
      bins_open = 0;
    end
    if (b.item_size <= bin_cap) begin
      for (int j = 0; j < bins_open; j++) begin
        if (!found && bin_room[j] >= b.item_size) begin
          bin_room[j]  = bin_room[j] - b.item_size;
          r.bin_number = 4'(j);
          r.rejected   = 1'b0;
          found        = 1'b1;
        end
      end
      if (!found && bins_open < NUM_BINS) begin
        bin_room[bins_open] = bin_cap - b.item_size;
        r.bin_number        = 4'(bins_open);
        r.opened_new_bin    = 1'b1;
        r.rejected          = 1'b0;
        bins_open++;
      end
    end
    r.bins_in_use = 5'(bins_open);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  task automatic send_item(input logic [15:0] size, input logic new_set);
    in_beat_t b;
    b.item_size     = size;
    b.start_new_set = new_set;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    expected_placements.push_back(place_item(b));
  endtask

  // Drop valid, wait out every pending result, then the worst-case scan time
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (NUM_BINS + 4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] cap);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
    bin_cap = cap;
  endtask

  function automatic logic [15:0] pick_size(logic [15:0] cap);
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return cap;
      2:       return (cap == 16'hFFFF) ? cap : 16'($urandom_range(cap + 1, 65535));
      3:       return '0;
      4, 5, 6: return 16'($urandom_range(0, cap));
      default: return 16'($urandom_range(cap / 2, cap));
    endcase
  endfunction

  function automatic logic [15:0] pick_capacity();
    case ($urandom_range(0, 6))
      0:       return 16'hFFFF;
      1:       return 16'd1;
      2:       return 16'd0;
      3:       return 16'($urandom_range(2, 64));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Zero-size item into an empty packer, full-capacity items at reset capacity
  task automatic test_reset_defaults();
    send_item(16'd0, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'd1, 1'b1);
  endtask

  // Capacity of zero: only zero-size items fit; oversized reject still clears
  task automatic test_zero_capacity();
    set_capacity(16'd0);
    send_item(16'd1, 1'b1);
    send_item(16'd0, 1'b0);
    send_item(16'd0, 1'b0);
  endtask

  // Fill every bin, then reject on full, then reject oversized with a new set
  task automatic test_full_bins();
    set_capacity(16'd1);
    send_item(16'd1, 1'b1);
    repeat (NUM_BINS - 1) send_item(16'd1, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd2, 1'b1);
    send_item(16'd0, 1'b0);
  endtask

  // Open bins keep their room when the capacity changes mid-set
  task automatic test_capacity_change();
    set_capacity(16'd100);
    send_item(16'd60, 1'b1);
    set_capacity(16'd50);
    send_item(16'd45, 1'b0);
    send_item(16'd40, 1'b0);
    send_item(16'd6, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_items, input int in_pct, input int out_pct);
    int          sent;
    int          set_left;
    int          chunk;
    logic [15:0] cap;
    logic        new_set;
    sent     = 0;
    set_left = 0;
    sender_idle_pct   = in_pct;
    receiver_idle_pct = out_pct;
    while (sent < n_items) begin
      cap = pick_capacity();
      set_capacity(cap);
      chunk = $urandom_range(20, 60);
      if (chunk > n_items - sent) begin
        chunk = n_items - sent;
      end
      repeat (chunk) begin
        new_set = (set_left == 0);
        if (new_set) begin
          set_left = $urandom_range(1, 40);
        end
        set_left--;
        send_item(pick_size(cap), new_set);
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    out_beat_t got;
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (expected_placements.size() == 0) begin
        flag_error($sformatf("result beat with none pending: bin %0d rejected %0b",
                             got.bin_number, got.rejected));
      end else begin
        want = expected_placements.pop_front();
        if (got.bin_number !== want.bin_number)
          flag_error($sformatf("bin_number: got %0d expected %0d",
                               got.bin_number, want.bin_number));
        if (got.opened_new_bin !== want.opened_new_bin)
          flag_error($sformatf("opened_new_bin: got %0b expected %0b",
                               got.opened_new_bin, want.opened_new_bin));
        if (got.rejected !== want.rejected)
          flag_error($sformatf("rejected: got %0b expected %0b",
                               got.rejected, want.rejected));
        if (got.bins_in_use !== want.bins_in_use)
          flag_error($sformatf("bins_in_use: got %0d expected %0d",
                               got.bins_in_use, want.bins_in_use));
      end
    end
  end

  // Watchdog: too long without a beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat in %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_zero_capacity();
    test_full_bins();
    test_capacity_change();
    test_random_traffic(234, 27, 65);
    test_random_traffic(234, 65, 27);
    test_random_traffic(234, 0, 0);
    drain_results();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
